>>> rtl/tabh_pkg.sv
// Shared types and constants for the tabulation hash block.
// Depends on nothing; the merge stage and the top level use it by scoped names.
`timescale 1ns / 1ps

package tabh_pkg;

    // Default build options
    localparam int KEY_WIDTH_DEF    = 32;
    localparam int SYMBOL_WIDTH_DEF = 8;
    localparam int HASH_WIDTH_DEF   = 32;

    // Fixed port widths
    localparam int OP_W    = 2;
    localparam int KEY_W   = 32;
    localparam int TSEL_W  = 2;
    localparam int SIDX_W  = 8;
    localparam int VALUE_W = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_HASH  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Control that travels with a transaction down the pipeline
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [TSEL_W-1:0] tsel;
    } ctl_t;

endpackage

>>> rtl/tabh_table.sv
// One symbol table: a single-port memory with registered read data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module tabh_table #(
    parameter int ADDR_WIDTH = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_WIDTH-1:0] addr,
    input  logic [DATA_WIDTH-1:0] wdata,
    output logic [DATA_WIDTH-1:0] rdata
);

    localparam int DEPTH = 2 ** ADDR_WIDTH;

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // Write the entry when enabled; the old entry is always read into the output register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tabh_merge.sv
// Last pipeline stage: XOR the table entries into the hash or pick one entry
// for a read-back, and register the result. Depends on tabh_pkg.
`timescale 1ns / 1ps

module tabh_merge #(
    parameter int NUM_TABLES = 4,
    parameter int HASH_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tabh_pkg::ctl_t                        ctl,
    input  logic [NUM_TABLES-1:0][HASH_WIDTH-1:0] rdata,
    output logic                                  done,
    output logic [tabh_pkg::VALUE_W-1:0]          value,
    output logic [tabh_pkg::OP_W-1:0]             kind
);

    localparam int TSEL_W     = tabh_pkg::TSEL_W;
    localparam int VALUE_W    = tabh_pkg::VALUE_W;
    localparam int SEL_LIMIT  = 2 ** TSEL_W;
    localparam int SEL_TABLES = (NUM_TABLES < SEL_LIMIT) ? NUM_TABLES : SEL_LIMIT;

    logic [HASH_WIDTH-1:0]     hash;
    logic [HASH_WIDTH-1:0]     sel;
    logic [HASH_WIDTH-1:0]     result;
    logic                      done_reg;
    logic [VALUE_W-1:0]        value_reg;
    logic [VALUE_W-1:0]        value_next;
    logic [tabh_pkg::OP_W-1:0] kind_reg;

    // Fold all table entries together
    always_comb
    begin
        hash = '0;
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            hash = hash ^ rdata[t];
        end
    end

    // Pick the addressed table; a table beyond the last reads as zero
    always_comb
    begin
        sel = '0;
        for (int t = 0; t < SEL_TABLES; t++)
        begin
            if (ctl.tsel == TSEL_W'(t))
            begin
                sel = rdata[t];
            end
        end
    end

    // Choose the result by operation; writes and the unused code give zero
    always_comb
    begin
        case (ctl.op)
            tabh_pkg::OP_HASH: result = hash;
            tabh_pkg::OP_READ: result = sel;
            default:           result = '0;
        endcase
        value_next = VALUE_W'(result);
    end

    // Strobe the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.valid;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            value_reg <= value_next;
            kind_reg  <= ctl.op;
        end
    end

    assign done  = done_reg;
    assign value = value_reg;
    assign kind  = kind_reg;

endmodule

>>> rtl/tabulation_hash_with_table_port_top.sv
// Top level of the simple tabulation hash with table write and read-back.
// Depends on tabh_pkg, tabh_table and tabh_merge.
`timescale 1ns / 1ps
//
//  channel   | handshake        | payload
//  ----------+------------------+-----------------------------------------------
//  request   | start / busy     | op, key, table_select, symbol_index, entry_value
//  result    | done (strobe)    | value, kind
//
// One transaction enters per cycle; busy stays low. Each result appears on
// done after the input register, the table read (the one port of each table
// memory) and the merge register. Every request gives one result.
// Reset clears the control registers of the pipeline only; table contents are
// undefined until written. The receiver cannot stall, so nothing is held.

module tabulation_hash_with_table_port_top #(
    parameter int KEY_WIDTH    = tabh_pkg::KEY_WIDTH_DEF,
    parameter int SYMBOL_WIDTH = tabh_pkg::SYMBOL_WIDTH_DEF,
    parameter int HASH_WIDTH   = tabh_pkg::HASH_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tabh_pkg::OP_W-1:0]     op,
    input  logic [tabh_pkg::KEY_W-1:0]    key,
    input  logic [tabh_pkg::TSEL_W-1:0]   table_select,
    input  logic [tabh_pkg::SIDX_W-1:0]   symbol_index,
    input  logic [tabh_pkg::VALUE_W-1:0]  entry_value,
    output logic                          done,
    output logic [tabh_pkg::VALUE_W-1:0]  value,
    output logic [tabh_pkg::OP_W-1:0]     kind
);

    localparam int NUM_TABLES = (KEY_WIDTH + SYMBOL_WIDTH - 1) / SYMBOL_WIDTH;
    localparam int TSEL_W     = tabh_pkg::TSEL_W;
    localparam int SEL_LIMIT  = 2 ** TSEL_W;

    tabh_pkg::ctl_t                       s1_ctl_reg;
    tabh_pkg::ctl_t                       s1_ctl_next;
    logic [KEY_WIDTH-1:0]                 s1_key_reg;
    logic [tabh_pkg::SIDX_W-1:0]          s1_sidx_reg;
    logic [HASH_WIDTH-1:0]                s1_wdata_reg;
    tabh_pkg::ctl_t                       s2_ctl_reg;
    logic [NUM_TABLES-1:0][HASH_WIDTH-1:0] rdata;

    // The pipeline takes a transaction every cycle
    assign busy = 1'b0;

    always_comb
    begin
        s1_ctl_next.valid = start;
        s1_ctl_next.op    = op;
        s1_ctl_next.tsel  = table_select;
    end

    // Advance the control through the input and table stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_key_reg   <= KEY_WIDTH'(key);
            s1_sidx_reg  <= symbol_index;
            s1_wdata_reg <= HASH_WIDTH'(entry_value);
        end
    end

    // One memory per symbol; the last one may be shorter
    for (genvar t = 0; t < NUM_TABLES; t++)
    begin : g_table
        localparam int REST = KEY_WIDTH - t * SYMBOL_WIDTH;
        localparam int AW   = (REST < SYMBOL_WIDTH) ? REST : SYMBOL_WIDTH;

        logic [AW-1:0] addr;
        logic          we;

        // Hash uses the key symbol, access uses the index wrapped to the table
        always_comb
        begin
            if (s1_ctl_reg.op == tabh_pkg::OP_HASH)
            begin
                addr = s1_key_reg[t * SYMBOL_WIDTH +: AW];
            end
            else
            begin
                addr = AW'(s1_sidx_reg);
            end
        end

        if (t < SEL_LIMIT)
        begin : g_wr
            assign we = s1_ctl_reg.valid && (s1_ctl_reg.op == tabh_pkg::OP_WRITE)
                        && (s1_ctl_reg.tsel == TSEL_W'(t));
        end
        else
        begin : g_no_wr
            assign we = 1'b0;
        end

        tabh_table #(
            .ADDR_WIDTH (AW),
            .DATA_WIDTH (HASH_WIDTH)
        ) u_table (
            .clk   (clk),
            .we    (we),
            .addr  (addr),
            .wdata (s1_wdata_reg),
            .rdata (rdata[t])
        );
    end

    tabh_merge #(
        .NUM_TABLES (NUM_TABLES),
        .HASH_WIDTH (HASH_WIDTH)
    ) u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (s2_ctl_reg),
        .rdata (rdata),
        .done  (done),
        .value (value),
        .kind  (kind)
    );

endmodule
